// ===== sv/cbp_pkg.sv =====
package cbp_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int VALUE_W    = 20;
  localparam int DIM_W      = 11;
  localparam int KROW_W     = 24;
  localparam int PROD_W     = 16;
  localparam int TAPS       = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // work queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [DIM_W-1:0]  WIDTH_RESET  = 11'd810;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd540;
  localparam logic [KROW_W-1:0] KROW_RESET   = 24'h010101;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0]             frame_width;
    logic [DIM_W-1:0]             frame_height;
    logic [2:0][KROW_W-1:0]       kernel;       // [0] row above, [2] row below
  } cfg_t;

  // which results one pixel request causes
  typedef struct packed {
    logic center;
    logic interior;
    logic right;
    logic last;
    logic frame_end;
  } emit_t;

  typedef struct packed {
    emit_t                        emit;
    logic [COORD_W-1:0]           x;
    logic [COORD_W-1:0]           y;
    logic [COORD_W-1:0]           xm1;
    logic [COORD_W-1:0]           ym1;
    logic [PIX_W-1:0]             center_pix;
    logic [PIX_W-1:0]             right_pix;
    logic [PIX_W-1:0]             last_pix;
    logic [TAPS-1:0][PROD_W-1:0]  prod;
  } work_t;

  // signed coefficient times unsigned pixel; the product always fits 16 bits
  function automatic logic [PROD_W-1:0] tap_product(input logic [7:0] coef,
                                                    input logic [7:0] pix);
    logic signed [16:0] full;
    full = $signed(coef) * $signed({1'b0, pix});
    return full[PROD_W-1:0];
  endfunction

endpackage

// ===== sv/conv3x3_border_passthrough_unit.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | pixel
// out     | output    | out_valid / out_ready| out_x, out_y, value, frame_end
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel a cycle while results drain at one a cycle; a pixel on a row end or
// on the last row can give two or three results, so there the single output
// register sets the pace. A request's first result passes the stage-1 registers
// and the queue before it is registered at the output.
// rst clears counters, window, queue and output valid; line buffers are not
// cleared. cfg_ready is always high. The front stalls only on queue credit.
module conv3x3_border_passthrough_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cbp_pkg::PIX_W-1:0]           pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cbp_pkg::COORD_W-1:0]         out_x,
  output logic [cbp_pkg::COORD_W-1:0]         out_y,
  output logic signed [cbp_pkg::VALUE_W-1:0]  value,
  output logic                                frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cbp_pkg::*;

  cfg_t              cfg;
  logic              push;
  work_t             push_data;
  logic              pop;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  work_t             q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= WIDTH_RESET;
      cfg.frame_height <= HEIGHT_RESET;
      cfg.kernel       <= {3{KROW_RESET}};
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:   cfg.frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  cfg.frame_height <= cfg_data[DIM_W-1:0];
        REG_KERNEL_TOP:    cfg.kernel[0]    <= cfg_data;
        REG_KERNEL_MIDDLE: cfg.kernel[1]    <= cfg_data;
        REG_KERNEL_BOTTOM: cfg.kernel[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  cbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  cbp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (q_empty),
    .count     (q_count),
    .head      (q_head)
  );

  cbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .value     (value),
    .frame_end (frame_end)
  );

endmodule

// ===== sv/cbp_front.sv =====
module cbp_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cbp_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cbp_pkg::PIX_W-1:0]    pixel,
  input  logic [cbp_pkg::QCNT_W-1:0]   q_count,
  output logic                         push,
  output cbp_pkg::work_t               push_data
);
  import cbp_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WDW = (XW + 1 > DIM_W) ? XW + 1 : DIM_W;
  localparam int HDW = (YW + 1 > DIM_W) ? YW + 1 : DIM_W;

  logic [WDW-1:0] width_ext;
  logic [HDW-1:0] height_ext;
  logic [XW-1:0]  last_col;
  logic [YW-1:0]  last_row;

  logic [XW-1:0] col_count;
  logic [YW-1:0] row_count;
  logic          accept;
  logic          row_end;
  logic          on_last_row;
  emit_t         emit_s0;

  logic          s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;
  emit_t         s1_emit;

  // entry: [15:8] two rows up, [7:0] one row up
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd;

  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0][2:0][PIX_W-1:0] win_next;

  always_comb begin
    width_ext  = WDW'(cfg.frame_width);
    height_ext = HDW'(cfg.frame_height);
    if (width_ext < WDW'(3)) begin
      last_col = XW'(2);
    end else if (width_ext > WDW'(MAX_WIDTH)) begin
      last_col = XW'(MAX_WIDTH - 1);
    end else begin
      last_col = XW'(width_ext - WDW'(1));
    end
    if (height_ext < HDW'(3)) begin
      last_row = YW'(2);
    end else if (height_ext > HDW'(MAX_HEIGHT)) begin
      last_row = YW'(MAX_HEIGHT - 1);
    end else begin
      last_row = YW'(height_ext - HDW'(1));
    end
  end

  // credit check: the pixel in flight always has a queue slot waiting
  assign in_ready = !rst &&
                    ((q_count + QCNT_W'(s1_valid)) < QCNT_W'(QDEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    row_end          = col_count >= last_col;
    on_last_row      = row_count >= last_row;
    emit_s0.center   = (row_count != '0) && (col_count != '0);
    emit_s0.interior = (col_count >= XW'(2)) && (row_count >= YW'(2)) &&
                       (col_count <= last_col) && (row_count <= last_row);
    emit_s0.right    = (row_count != '0) && row_end;
    emit_s0.last     = on_last_row;
    emit_s0.frame_end = on_last_row && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= on_last_row ? '0 : row_count + YW'(1);
      end else begin
        col_count <= col_count + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pixel;
      s1_x    <= col_count;
      s1_y    <= row_count;
      s1_emit <= emit_s0;
    end
  end

  // consecutive pixels never share a column, so read and write never collide
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col_count];
    end
    if (s1_valid) begin
      line_mem[s1_x] <= {line_rd[PIX_W-1:0], s1_pix};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = line_rd[2*PIX_W-1:PIX_W];
    win_next[1][2] = line_rd[PIX_W-1:0];
    win_next[2][2] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  assign push = s1_valid;

  always_comb begin
    push_data.emit       = s1_emit;
    push_data.x          = COORD_W'(s1_x);
    push_data.y          = COORD_W'(s1_y);
    push_data.xm1        = COORD_W'(s1_x - XW'(1));
    push_data.ym1        = COORD_W'(s1_y - YW'(1));
    push_data.center_pix = win_next[1][1];
    push_data.right_pix  = win_next[1][2];
    push_data.last_pix   = s1_pix;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_data.prod[r*3 + c] = tap_product(cfg.kernel[r][8*c +: 8], win_next[r][c]);
      end
    end
  end

endmodule

// ===== sv/cbp_fifo.sv =====
module cbp_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  cbp_pkg::work_t              push_data,
  input  logic                        pop,
  output logic                        empty,
  output logic [cbp_pkg::QCNT_W-1:0]  count,
  output cbp_pkg::work_t              head
);
  import cbp_pkg::*;

  work_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      priority if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end else begin
        count <= count;
      end
    end
  end

endmodule

// ===== sv/cbp_back.sv =====
module cbp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  cbp_pkg::work_t                      head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cbp_pkg::COORD_W-1:0]         out_x,
  output logic [cbp_pkg::COORD_W-1:0]         out_y,
  output logic signed [cbp_pkg::VALUE_W-1:0]  value,
  output logic                                frame_end
);
  import cbp_pkg::*;

  // bit 0 centre result, bit 1 right-column pass, bit 2 last-row pass
  logic [2:0] done;
  logic [2:0] done_next;
  logic [2:0] pend;
  logic [2:0] sel;
  logic       issue;
  logic signed [VALUE_W-1:0] sum;

  always_comb begin
    pend = {head.emit.last, head.emit.right, head.emit.center} & ~done;
    priority if (pend[0]) begin
      sel = 3'b001;
    end else if (pend[1]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end
  end

  assign issue = !q_empty && (pend != '0) && (!out_valid || out_ready);
  // a record with nothing to give is dropped without waiting for the output
  assign pop   = !q_empty && ((pend == '0) || (issue && ((pend & ~sel) == '0)));

  always_comb begin
    priority if (pop) begin
      done_next = '0;
    end else if (issue) begin
      done_next = done | sel;
    end else begin
      done_next = done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else begin
      done <= done_next;
    end
  end

  always_comb begin
    sum = '0;
    for (int t = 0; t < TAPS; t++) begin
      sum = sum + VALUE_W'($signed(head.prod[t]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      priority if (sel[0]) begin
        out_x     <= head.xm1;
        out_y     <= head.ym1;
        value     <= head.emit.interior ? sum : VALUE_W'(head.center_pix);
        frame_end <= 1'b0;
      end else if (sel[1]) begin
        out_x     <= head.x;
        out_y     <= head.ym1;
        value     <= VALUE_W'(head.right_pix);
        frame_end <= 1'b0;
      end else begin
        out_x     <= head.x;
        out_y     <= head.y;
        value     <= VALUE_W'(head.last_pix);
        frame_end <= head.emit.frame_end;
      end
    end
  end

endmodule

// ===== sv/cbp_checker.sv =====
module cbp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cbp_pkg::COORD_W-1:0]         out_x,
  input logic [cbp_pkg::COORD_W-1:0]         out_y,
  input logic signed [cbp_pkg::VALUE_W-1:0]  value,
  input logic                                frame_end
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_request_in_reset: assert property (@(posedge clk) rst |-> !in_ready)
    else $error("input ready during reset");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) &&
                                $stable(value) && $stable(frame_end))
    else $error("result changed while stalled");

  // the last result of a frame is a bottom-row pass-through pixel
  a_frame_end_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> value[cbp_pkg::VALUE_W-1:cbp_pkg::PIX_W] == '0)
    else $error("frame end on a non pass-through value");

endmodule

bind conv3x3_border_passthrough_unit cbp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .value     (value),
  .frame_end (frame_end)
);

// ===== tb/sv/conv3x3_border_passthrough_unit_tb.sv =====
module conv3x3_border_passthrough_unit_tb;
  import cbp_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [VALUE_W-1:0] val;
    logic               fe;
  } pix_result_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [PIX_W-1:0]            pixel;
  logic                        out_valid;
  logic                        out_ready;
  logic [COORD_W-1:0]          out_x;
  logic [COORD_W-1:0]          out_y;
  logic signed [VALUE_W-1:0]   value;
  logic                        frame_end;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;

  // predictor state
  logic [DIM_W-1:0]  cfg_width;
  logic [DIM_W-1:0]  cfg_height;
  logic [KROW_W-1:0] kernel_row [3];
  logic [PIX_W-1:0]  line1 [MAX_W];
  logic [PIX_W-1:0]  line2 [MAX_W];
  logic [PIX_W-1:0]  win [3][3];
  int unsigned       frame_col;
  int unsigned       frame_row;

  pix_result_t expected_results [$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  bit          src_gaps = 1'b0;
  bit          sink_stalls = 1'b0;

  conv3x3_border_passthrough_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .value     (value),
    .frame_end (frame_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned hi);
    if ($urandom_range(0, 9) == 0) return DIM_W'($urandom_range(0, 2));
    return DIM_W'($urandom_range(3, hi));
  endfunction

  function automatic int window_sum();
    int s;
    int r;
    int c;
    s = 0;
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        s += int'($signed(kernel_row[r][8*c +: 8])) * int'(win[r][c]);
    return s;
  endfunction

  task automatic reset_predictor();
    int i;
    cfg_width  = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    for (i = 0; i < 3; i++) kernel_row[i] = KROW_RESET;
    for (i = 0; i < MAX_W; i++) begin
      line1[i] = '0;
      line2[i] = '0;
    end
    for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
    frame_col = 0;
    frame_row = 0;
  endtask

  task automatic expect_result(input int unsigned x, input int unsigned y, input int v,
                               input bit fe);
    pix_result_t res;
    res.x   = x[COORD_W-1:0];
    res.y   = y[COORD_W-1:0];
    res.val = v[VALUE_W-1:0];
    res.fe  = fe;
    expected_results.push_back(res);
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] p);
    int unsigned w, h, x, y, xi, cx, cy;
    bit row_end, last_row;
    int r;
    w  = eff_dim(cfg_width, MAX_W);
    h  = eff_dim(cfg_height, MAX_H);
    x  = frame_col;
    y  = frame_row;
    xi = (x < MAX_W) ? x : MAX_W - 1;
    row_end  = (x >= w - 1);
    last_row = (y >= h - 1);
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line2[xi];
    win[1][2] = line1[xi];
    win[2][2] = p;
    if (y >= 1) begin
      if (x >= 1) begin
        cx = x - 1;
        cy = y - 1;
        if (cx >= 1 && cy >= 1 && cx < w - 1 && cy < h - 1)
          expect_result(cx, cy, window_sum(), 1'b0);
        else
          expect_result(cx, cy, int'(win[1][1]), 1'b0);
      end
      if (row_end) expect_result(x, y - 1, int'(win[1][2]), 1'b0);
    end
    if (last_row) expect_result(x, y, int'(p), row_end);
    line2[xi] = line1[xi];
    line1[xi] = p;
    if (row_end) begin
      frame_col = 0;
      frame_row = last_row ? 0 : y + 1;
    end else begin
      frame_col = x + 1;
    end
  endtask

  // all tasks below start and end on a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int unsigned gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel    = p;
    do @(posedge clk); while (!in_ready);
    predict_pixel(p);
    pixels_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:   cfg_width     = data[DIM_W-1:0];
      REG_FRAME_HEIGHT:  cfg_height    = data[DIM_W-1:0];
      REG_KERNEL_TOP:    kernel_row[0] = data[KROW_W-1:0];
      REG_KERNEL_MIDDLE: kernel_row[1] = data[KROW_W-1:0];
      REG_KERNEL_BOTTOM: kernel_row[2] = data[KROW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // a pixel may cause no result, so allow for the pipeline after draining
  task automatic wait_idle();
    wait_results_drained();
    repeat (8) @(negedge clk);
  endtask

  // height clamped high, then width shrunk and height cut while mid-frame
  task automatic test_midframe_change();
    int i;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    write_reg(REG_FRAME_WIDTH, 24'd5);
    write_reg(REG_FRAME_HEIGHT, 24'd2047);
    for (i = 0; i < 11; i++) begin
      if (i == 7) begin
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 24'd3);
        write_reg(REG_FRAME_HEIGHT, 24'd3);
      end
      send_pixel((i % 2) ? 8'hFF : 8'h00);
    end
  endtask

  task automatic test_extreme_values();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    wait_idle();
    // junk above bit 10 must be dropped; height 0 clamps up
    write_reg(REG_FRAME_WIDTH, 24'hFFF803);
    write_reg(REG_FRAME_HEIGHT, 24'h000000);
    write_reg(REG_KERNEL_TOP, 24'h808080);
    write_reg(REG_KERNEL_MIDDLE, 24'h808080);
    write_reg(REG_KERNEL_BOTTOM, 24'h808080);
    repeat (9) send_pixel(8'hFF);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 24'd1);
    write_reg(REG_FRAME_HEIGHT, 24'd2);
    write_reg(REG_KERNEL_TOP, 24'h7F7F7F);
    write_reg(REG_KERNEL_MIDDLE, 24'h7F7F7F);
    write_reg(REG_KERNEL_BOTTOM, 24'h7F7F7F);
    repeat (9) send_pixel(8'hFF);
  endtask

  task automatic test_random_frames();
    int unsigned goal, cut, in_frame;
    logic [12:0] junk;
    goal = pixels_sent + 150;
    while (pixels_sent < goal) begin
      wait_idle();
      junk = 13'($urandom);
      write_reg(REG_FRAME_WIDTH, {junk, pick_dim(10)});
      junk = 13'($urandom);
      write_reg(REG_FRAME_HEIGHT, {junk, pick_dim(5)});
      if ($urandom_range(0, 1)) write_reg(REG_KERNEL_TOP, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_KERNEL_MIDDLE, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_KERNEL_BOTTOM, CFG_DATA_W'($urandom));
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
      in_frame = 0;
      do begin
        if (cut != 0 && in_frame == cut) begin
          wait_idle();
          // width may only shrink mid-frame, or unwritten line entries get read
          case ($urandom_range(0, 4))
            0: write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(pick_dim(5)));
            1: write_reg(REG_FRAME_WIDTH,
                         CFG_DATA_W'($urandom_range(0, eff_dim(cfg_width, MAX_W))));
            2: write_reg(REG_KERNEL_TOP, CFG_DATA_W'($urandom));
            3: write_reg(REG_KERNEL_MIDDLE, CFG_DATA_W'($urandom));
            default: write_reg(REG_KERNEL_BOTTOM, CFG_DATA_W'($urandom));
          endcase
        end
        if ($urandom_range(0, 39) == 0) wait_results_drained();
        send_pixel(pick_pixel());
        in_frame++;
      end while (frame_col != 0 || frame_row != 0);
    end
  endtask

  // start of a row whose width clamps to the maximum: no early row end
  task automatic test_wide_frame();
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 24'h0007FF);
    write_reg(REG_FRAME_HEIGHT, 24'd3);
    write_reg(REG_KERNEL_TOP, CFG_DATA_W'($urandom));
    write_reg(REG_KERNEL_MIDDLE, CFG_DATA_W'($urandom));
    write_reg(REG_KERNEL_BOTTOM, CFG_DATA_W'($urandom));
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    repeat (30) send_pixel(pick_pixel());
  endtask

  initial begin : sink_driver
    int unsigned hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 30) hold = pick_gap() + 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d value=%0d frame_end=%0b",
                 $time, out_x, out_y, value, frame_end);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if ({out_x, out_y, value, frame_end} !== want) begin
          $display("%0t: mismatch expected x=%0d y=%0d value=%0d frame_end=%0b",
                   $time, want.x, want.y, $signed(want.val), want.fe);
          $display("%0t:          actual   x=%0d y=%0d value=%0d frame_end=%0b",
                   $time, out_x, out_y, value, frame_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    pixel     = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_midframe_change();
    test_extreme_values();
    test_random_frames();
    test_wide_frame();
    wait_results_drained();
    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cbp_pkg.sv
sv/cbp_front.sv
sv/cbp_fifo.sv
sv/cbp_back.sv
sv/conv3x3_border_passthrough_unit.sv
sv/cbp_checker.sv
tb/sv/conv3x3_border_passthrough_unit_tb.sv
